// ===== rtl/bave_pkg.sv =====
`timescale 1ns / 1ps

package bave_pkg;

    // Configuration register indexes
    localparam logic REG_BLOCK_WIDTH  = 1'b0;
    localparam logic REG_BLOCK_HEIGHT = 1'b1;

    // Block dimension lower limit and reset value
    localparam logic [3:0] MIN_DIM   = 4'd4;
    localparam logic [3:0] RESET_DIM = 4'd4;

    // Void-extent header, 2D LDR, all extent coordinates ones
    localparam logic [63:0] VOID_EXTENT_HEADER = 64'hFFFF_FFFF_FFFF_FDFC;

    // Four color channels, UNORM16 averages
    localparam int  CH_N    = 4;
    localparam int  Q_W     = 16;
    localparam logic [1:0] CH_LAST = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic       accum;    // add accepted texel into the sums
        logic       load;     // form numerator and divisor of one channel
        logic       step;     // one restoring-division step
        logic       store;    // final step: keep the quotient
        logic       clear;    // clear sums and count for the next block
        logic       sel_col;  // drive the color word instead of the header
        logic [1:0] ch;       // channel under division
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic last;           // the offered texel completes the block
    } t_sts;

endpackage

// ===== rtl/bave_datapath.sv =====
`timescale 1ns / 1ps

module bave_datapath
    import bave_pkg::*;
#(
    parameter int MAX_BLOCK_DIM = 12,
    parameter int CNT_W         = 8,
    parameter int SUM_W         = 16,
    parameter int NUM_W         = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic        i_cfg_idx,
    input  logic [3:0]  i_cfg_wdata,
    input  logic [31:0] i_pixel,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic [63:0] o_word
);

    localparam int DIV_W = CNT_W + 1;
    localparam logic [3:0] MAX_DIM = 4'(MAX_BLOCK_DIM);

    logic [3:0]       r_block_width;
    logic [3:0]       r_block_height;
    logic [SUM_W-1:0] r_sum [CH_N];
    logic [CNT_W-1:0] r_count;
    logic [NUM_W-1:0] r_num;
    logic [DIV_W-1:0] r_div;
    logic [DIV_W-1:0] r_rem;
    logic [Q_W-1:0]   r_quo;
    logic [Q_W-1:0]   r_col [CH_N];

    logic [3:0]       w_dim_w;
    logic [3:0]       w_dim_h;
    logic [7:0]       w_area;
    logic [CNT_W-1:0] w_target;
    logic [CNT_W-1:0] w_cnt_inc;
    logic [SUM_W-1:0] w_sum_sel;
    logic [NUM_W-1:0] w_num_init;
    logic [DIV_W:0]   w_rem_sh;
    logic [DIV_W:0]   w_rem_sub;
    logic             w_ge;
    logic [DIV_W-1:0] n_rem;
    logic [Q_W-1:0]   n_quo;

    // Clamp dimensions and form the texel count of one block
    always_comb begin
        w_dim_w = (r_block_width < MIN_DIM) ? MIN_DIM :
                  (r_block_width > MAX_DIM) ? MAX_DIM : r_block_width;
        w_dim_h = (r_block_height < MIN_DIM) ? MIN_DIM :
                  (r_block_height > MAX_DIM) ? MAX_DIM : r_block_height;
        w_area   = {4'b0, w_dim_w} * {4'b0, w_dim_h};
        w_target = CNT_W'(w_area);
    end

    assign w_cnt_inc  = r_count + CNT_W'(1);
    assign o_sts.last = (w_cnt_inc >= w_target);

    // Numerator 514*sum + count, as two shifted copies of the sum
    assign w_sum_sel  = r_sum[i_cmd.ch];
    assign w_num_init = NUM_W'({w_sum_sel, 9'b0}) + NUM_W'({w_sum_sel, 1'b0})
                      + NUM_W'(r_count);

    // One restoring-division step
    always_comb begin
        w_rem_sh  = {r_rem, r_num[NUM_W-1]};
        w_rem_sub = w_rem_sh - {1'b0, r_div};
        w_ge      = (w_rem_sh >= {1'b0, r_div});
        n_rem     = w_ge ? w_rem_sub[DIV_W-1:0] : w_rem_sh[DIV_W-1:0];
        n_quo     = {r_quo[Q_W-2:0], w_ge};
    end

    // Hold the block dimensions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_width  <= RESET_DIM;
            r_block_height <= RESET_DIM;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                REG_BLOCK_WIDTH:  r_block_width  <= i_cfg_wdata;
                REG_BLOCK_HEIGHT: r_block_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Accumulate texels, clear after the block is encoded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < CH_N; i++) r_sum[i] <= '0;
            r_count <= '0;
        end else if (i_cmd.accum) begin
            for (int i = 0; i < CH_N; i++) begin
                r_sum[i] <= r_sum[i] + SUM_W'(i_pixel[8*i +: 8]);
            end
            r_count <= w_cnt_inc;
        end
    end

    // Shared divider and color store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num <= w_num_init;
            r_div <= {r_count, 1'b0};
            r_rem <= '0;
        end else if (i_cmd.step) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
        if (i_cmd.store) begin
            r_col[i_cmd.ch] <= n_quo;
        end
    end

    assign o_word = i_cmd.sel_col ? {r_col[3], r_col[2], r_col[1], r_col[0]}
                                  : VOID_EXTENT_HEADER;

endmodule

// ===== rtl/bave_ctrl.sv =====
`timescale 1ns / 1ps

module bave_ctrl
    import bave_pkg::*;
#(
    parameter int STEP_N = 25
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    output logic o_m_tlast,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam int STEP_W = $clog2(STEP_N);

    typedef enum logic [2:0] {
        S_ACCUM,
        S_LOAD,
        S_DIV,
        S_HDR,
        S_COL
    } t_state;

    t_state            r_state, n_state;
    logic [1:0]        r_ch, n_ch;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_s_tready, n_s_tready;
    logic              r_m_tvalid, n_m_tvalid;
    logic              r_m_tlast, n_m_tlast;

    // Sequence accumulation, four divisions and two output transfers
    always_comb begin
        n_state       = r_state;
        n_ch          = r_ch;
        n_step        = r_step;
        o_cmd         = '0;
        o_cmd.ch      = r_ch;
        o_cmd.sel_col = (r_state == S_COL);
        case (r_state)
            S_ACCUM: begin
                if (i_s_tvalid && r_s_tready) begin
                    o_cmd.accum = 1'b1;
                    n_ch        = '0;
                    if (i_sts.last) n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_step     = STEP_W'(STEP_N - 1);
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (r_step == '0) begin
                    o_cmd.store = 1'b1;
                    if (r_ch == CH_LAST) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_HDR;
                    end else begin
                        n_ch    = r_ch + 2'd1;
                        n_state = S_LOAD;
                    end
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end
            S_HDR: begin
                if (i_m_tready) n_state = S_COL;
            end
            S_COL: begin
                if (i_m_tready) n_state = S_ACCUM;
            end
            default: n_state = S_ACCUM;
        endcase
        n_s_tready = (n_state == S_ACCUM);
        n_m_tvalid = (n_state == S_HDR) || (n_state == S_COL);
        n_m_tlast  = (n_state == S_COL);
    end

    // Hold state and registered handshake outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_ACCUM;
            r_ch       <= '0;
            r_step     <= '0;
            r_s_tready <= 1'b0;
            r_m_tvalid <= 1'b0;
            r_m_tlast  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ch       <= n_ch;
            r_step     <= n_step;
            r_s_tready <= n_s_tready;
            r_m_tvalid <= n_m_tvalid;
            r_m_tlast  <= n_m_tlast;
        end
    end

    assign o_s_tready = r_s_tready;
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tlast  = r_m_tlast;

endmodule

// ===== rtl/block_average_void_extent_encoder.sv =====
`timescale 1ns / 1ps

// Constant-color block encoder (void-extent block, 2D LDR).
// Slave stream: one RGBA8 texel per transfer, raster order, edge texels
// already replicated. Block size comes from the write port: index 0 is
// block width, index 1 block height, clamped to 4..MAX_BLOCK_DIM.
// Master stream: two 64-bit words per block, the void-extent header first
// (tlast low), then the UNORM16 averages R, G, B, A from low to high (tlast
// high). Each average is round-half-up of sum*257/count.
// Timing: texels are taken one per cycle while a block accumulates. After
// the last texel of a block a shared restoring divider works one quotient
// bit per cycle on the four channels in turn, each loaded into it first,
// and then the header is offered.
// No texel is taken while the block divides or while its words are shown.
// A stalled receiver holds the current word; the block waits.
// Reset clears sums, count and handshake state and sets both dimensions to
// 4; tready is registered and rises in the cycle after reset is released.
module block_average_void_extent_encoder
    import bave_pkg::*;
#(
    parameter int MAX_BLOCK_DIM = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic        i_cfg_idx,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // red, green, blue, alpha
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // block_word
    output logic        o_m_axis_tlast    // last_word
);

    localparam int MAX_SQ = MAX_BLOCK_DIM * MAX_BLOCK_DIM;
    localparam int CNT_W  = $clog2(MAX_SQ + 1);
    localparam int SUM_W  = $clog2(255 * MAX_SQ + 1);
    localparam int NUM_W  = $clog2(255 * MAX_SQ * 514 + MAX_SQ + 1);

    t_cmd w_cmd;
    t_sts w_sts;

    bave_ctrl #(
        .STEP_N (NUM_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tlast  (o_m_axis_tlast),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bave_datapath #(
        .MAX_BLOCK_DIM (MAX_BLOCK_DIM),
        .CNT_W         (CNT_W),
        .SUM_W         (SUM_W),
        .NUM_W         (NUM_W)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pixel     (i_s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_word      (o_m_axis_tdata)
    );

endmodule

// ===== rtl/bave_checker.sv =====
`timescale 1ns / 1ps

module bave_checker
    import bave_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] i_m_tdata,
    input logic        i_m_tlast
);

    // Input side is closed while a block's words are offered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> !i_s_tready)
        else $error("texel input open while output words pending");

    // Header transfer is followed by the color word
    a_color_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tready && !i_m_tlast) |=> (i_m_tvalid && i_m_tlast))
        else $error("color word does not follow header");

    // First word of a block carries the void-extent header
    a_header_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tlast) |-> (i_m_tdata == VOID_EXTENT_HEADER))
        else $error("wrong header word");

    // Stalled output word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=>
            (i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast)))
        else $error("output word changed while stalled");

endmodule

bind block_average_void_extent_encoder bave_checker u_bave_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tlast  (o_m_axis_tlast)
);
